### hdl/convex_polygon_intersection_test_macros.svh
// assertion macros of the convex polygon intersection test rtl, used by the controller
`ifndef CONVEX_POLYGON_INTERSECTION_TEST_MACROS_SVH
`define CONVEX_POLYGON_INTERSECTION_TEST_MACROS_SVH

`ifndef NO_ASSERTIONS
`define CPIT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define CPIT_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define CPIT_ASSERT(lbl, prop, msg)
`define CPIT_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

### hdl/cpit_pkg.sv
// shared types and constants of the convex polygon intersection test
package cpit_pkg;

	localparam int MAX_VERTICES_DEF = 1024;
	localparam int COORD_BITS_DEF   = 32;

	localparam int SW = 32;       // stored coordinate width
	localparam int PW = SW + 1;   // polygon coordinate, negation included
	localparam int DW = SW + 2;   // difference point and edge width
	localparam int MW = 2 * DW;   // product width

	typedef logic signed [PW-1:0] pval_t;
	typedef logic signed [DW-1:0] dval_t;
	typedef logic signed [MW-1:0] prod_t;

	typedef enum logic [1:0] {
		OP_PAIR,
		OP_CLOSE,
		OP_ANG
	} mul_op_t;

	typedef enum logic [4:0] {
		ST_LOAD,
		ST_START,
		ST_SCAN1,
		ST_SCAN2,
		ST_FETCH0,
		ST_FETCH1,
		ST_FETCH2,
		ST_PAIR1,
		ST_PAIR2,
		ST_PAIR3,
		ST_ANG1,
		ST_ANG2,
		ST_ANG3,
		ST_ADV,
		ST_ADVW,
		ST_CLOSE1,
		ST_CLOSE2,
		ST_CLOSE3,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic    scan_en;
		logic    scan_first;
		logic    scan_neg;
		logic    ld_cur;
		logic    ld_nxt_p;
		logic    ld_nxt_q;
		logic    shift_p;
		logic    shift_q;
		logic    mul1;
		logic    mul2;
		mul_op_t op;
		logic    pair_upd;
		logic    store_first;
		logic    store_prev;
		logic    clr_flags;
	} dp_cmd_t;

	typedef struct packed {
		logic better;
		logic a_first;
		logic b_first;
		logic hit;
	} dp_sts_t;

endpackage

### hdl/cpit_ram.sv
// generic single write, single read ram with registered read data
module cpit_ram #(
	parameter int W = 64,
	parameter int D = 1024
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### hdl/cpit_dp.sv
// datapath: vertex packing, start search, edge merge and origin test arithmetic
module cpit_dp #(
	parameter int COORD_BITS = cpit_pkg::COORD_BITS_DEF
) (
	input  logic              clk,
	input  logic [31:0]       x_coord,
	input  logic [31:0]       y_coord,
	output logic [63:0]       wdata,
	input  logic [63:0]       rdata1,
	input  logic [63:0]       rdata2,
	input  cpit_pkg::dp_cmd_t cmd,
	output cpit_pkg::dp_sts_t sts
);

	localparam int DW = cpit_pkg::DW;
	localparam int MW = cpit_pkg::MW;

	function automatic logic [1:0] dir_group(input cpit_pkg::dval_t x, input cpit_pkg::dval_t y);
		logic [1:0] g;
		if (x > 0) g = 2'd0;
		else if (x == 0 && y > 0) g = 2'd1;
		else if (x < 0) g = 2'd2;
		else g = 2'd3;
		return g;
	endfunction

	logic signed [31:0] xs, ys;
	cpit_pkg::pval_t px, py, qx, qy, sx, sy;
	cpit_pkg::pval_t p_cur_x_q, p_cur_y_q, p_nxt_x_q, p_nxt_y_q;
	cpit_pkg::pval_t q_cur_x_q, q_cur_y_q, q_nxt_x_q, q_nxt_y_q;
	cpit_pkg::pval_t best_x_q, best_y_q;
	cpit_pkg::dval_t prev_x_q, prev_y_q, first_x_q, first_y_q;
	cpit_pkg::dval_t d_x, d_y, b_x, b_y;
	cpit_pkg::dval_t e_ax, e_ay, e_bx, e_by, ma, mb;
	cpit_pkg::prod_t prod1_q, prod2_q;
	logic signed [MW:0] xdiff;
	logic x_neg, x_pos, crossing, flip, s_pos, s_neg, upd_le, upd_ge;
	logic le_q, ge_q;
	logic better, a_first, b_first;
	logic [1:0] ga, gb;

	assign xs = 32'($signed(x_coord[COORD_BITS-1:0]));
	assign ys = 32'($signed(y_coord[COORD_BITS-1:0]));
	assign wdata = {ys, xs};

	// second polygon is negated as it is read
	assign px = cpit_pkg::PW'($signed(rdata1[31:0]));
	assign py = cpit_pkg::PW'($signed(rdata1[63:32]));
	assign qx = -cpit_pkg::PW'($signed(rdata2[31:0]));
	assign qy = -cpit_pkg::PW'($signed(rdata2[63:32]));

	assign sx = cmd.scan_neg ? qx : px;
	assign sy = cmd.scan_neg ? qy : py;
	assign better = (sx < best_x_q) || (sx == best_x_q && sy < best_y_q);

	assign d_x = DW'(p_cur_x_q) + DW'(q_cur_x_q);
	assign d_y = DW'(p_cur_y_q) + DW'(q_cur_y_q);
	assign b_x = (cmd.op == cpit_pkg::OP_CLOSE) ? first_x_q : d_x;
	assign b_y = (cmd.op == cpit_pkg::OP_CLOSE) ? first_y_q : d_y;

	assign e_ax = DW'(p_nxt_x_q) - DW'(p_cur_x_q);
	assign e_ay = DW'(p_nxt_y_q) - DW'(p_cur_y_q);
	assign e_bx = DW'(q_nxt_x_q) - DW'(q_cur_x_q);
	assign e_by = DW'(q_nxt_y_q) - DW'(q_cur_y_q);

	// one shared multiplier: first product a*b, second c*d
	always_comb begin
		case (cmd.op)
			cpit_pkg::OP_ANG: begin
				ma = cmd.mul1 ? e_ax : e_ay;
				mb = cmd.mul1 ? e_by : e_bx;
			end
			default: begin
				ma = cmd.mul1 ? prev_x_q : b_x;
				mb = cmd.mul1 ? b_y : prev_y_q;
			end
		endcase
	end

	assign xdiff = (MW+1)'(prod1_q) - (MW+1)'(prod2_q);
	assign x_neg = xdiff[MW];
	assign x_pos = !x_neg && (xdiff != '0);

	assign ga = dir_group(e_ax, e_ay);
	assign gb = dir_group(e_bx, e_by);

	always_comb begin
		a_first = 1'b0;
		b_first = 1'b0;
		if (ga != gb) begin
			a_first = ga < gb;
			b_first = ga > gb;
		end else if (ga == 2'd0 || ga == 2'd2) begin
			a_first = x_pos;
			b_first = x_neg;
		end
	end

	// boundary meets y = 0 at a vertex or by an interpolated crossing
	assign crossing = (prev_y_q < 0 && b_y > 0) || (prev_y_q > 0 && b_y < 0);
	assign flip = b_y < prev_y_q;
	assign s_pos = flip ? x_neg : x_pos;
	assign s_neg = flip ? x_pos : x_neg;
	assign upd_le = (prev_y_q == 0 && prev_x_q <= 0) || (crossing && !s_pos);
	assign upd_ge = (prev_y_q == 0 && prev_x_q >= 0) || (crossing && !s_neg);

	assign sts = '{better: better, a_first: a_first, b_first: b_first, hit: le_q && ge_q};

	always_ff @(posedge clk) begin
		if (cmd.scan_en && (cmd.scan_first || better)) begin
			best_x_q <= sx;
			best_y_q <= sy;
		end
		if (cmd.ld_cur) begin
			p_cur_x_q <= px;
			p_cur_y_q <= py;
			q_cur_x_q <= qx;
			q_cur_y_q <= qy;
		end
		if (cmd.shift_p) begin
			p_cur_x_q <= p_nxt_x_q;
			p_cur_y_q <= p_nxt_y_q;
		end
		if (cmd.shift_q) begin
			q_cur_x_q <= q_nxt_x_q;
			q_cur_y_q <= q_nxt_y_q;
		end
		if (cmd.ld_nxt_p) begin
			p_nxt_x_q <= px;
			p_nxt_y_q <= py;
		end
		if (cmd.ld_nxt_q) begin
			q_nxt_x_q <= qx;
			q_nxt_y_q <= qy;
		end
		if (cmd.store_first) begin
			first_x_q <= d_x;
			first_y_q <= d_y;
		end
		if (cmd.store_prev) begin
			prev_x_q <= d_x;
			prev_y_q <= d_y;
		end
		if (cmd.mul1) begin
			prod1_q <= ma * mb;
		end
		if (cmd.mul2) begin
			prod2_q <= ma * mb;
		end
		if (cmd.clr_flags) begin
			le_q <= 1'b0;
			ge_q <= 1'b0;
		end else if (cmd.pair_upd) begin
			le_q <= le_q || upd_le;
			ge_q <= ge_q || upd_ge;
		end
	end

endmodule

### hdl/cpit_ctrl.sv
// controller: vertex loading, start search, merge walk sequencing and result register
`include "convex_polygon_intersection_test_macros.svh"

module cpit_ctrl #(
	parameter int MAX_VERTICES = cpit_pkg::MAX_VERTICES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic                            s_sel,
	input  logic                            s_last,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic                            m_intersects,
	output logic                            m_overflow,
	output logic                            we1,
	output logic                            we2,
	output logic [$clog2(MAX_VERTICES)-1:0] waddr,
	output logic [$clog2(MAX_VERTICES)-1:0] raddr1,
	output logic [$clog2(MAX_VERTICES)-1:0] raddr2,
	output cpit_pkg::dp_cmd_t               cmd,
	input  cpit_pkg::dp_sts_t               sts
);

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam logic [CW-1:0] CAP = CW'(MAX_VERTICES);

	function automatic logic [AW-1:0] dec_wrap(input logic [AW-1:0] p, input logic [CW-1:0] n);
		return (p == '0) ? AW'(n - 1'b1) : p - 1'b1;
	endfunction

	cpit_pkg::state_t st_q, st_d;
	logic [CW-1:0] n1_q, n2_q, scan_q, i_q, j_q;
	logic [AW-1:0] best1_q, best2_q, pptr_q, qptr_q;
	logic ovf_q, have_prev_q, advp_q, advq_q, empty_q;
	logic m_tvalid_q, res_q, res_ovf_q;
	logic s_acc, out_load, done_i, done_j, scan_end;

	assign s_tready = (st_q == cpit_pkg::ST_LOAD);
	assign s_acc = s_tvalid && s_tready;
	assign out_load = (st_q == cpit_pkg::ST_OUT) && (!m_tvalid_q || m_tready);
	assign done_i = i_q >= n1_q;
	assign done_j = j_q >= n2_q;
	assign scan_end = (st_q == cpit_pkg::ST_SCAN1) ? (scan_q == n1_q - 1'b1)
		: (scan_q == n2_q - 1'b1);

	assign we1 = s_acc && !s_sel && (n1_q < CAP);
	assign we2 = s_acc && s_sel && (n2_q < CAP);
	assign waddr = s_sel ? n2_q[AW-1:0] : n1_q[AW-1:0];

	assign m_tvalid = m_tvalid_q;
	assign m_intersects = res_q;
	assign m_overflow = res_ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= cpit_pkg::ST_LOAD;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d = st_q;
		cmd = '0;
		cmd.op = cpit_pkg::OP_PAIR;
		raddr1 = '0;
		raddr2 = '0;
		case (st_q)
			cpit_pkg::ST_LOAD: begin
				if (s_acc && s_sel && s_last) st_d = cpit_pkg::ST_START;
			end
			cpit_pkg::ST_START: begin
				cmd.clr_flags = 1'b1;
				st_d = (n1_q == '0 || n2_q == '0) ? cpit_pkg::ST_OUT : cpit_pkg::ST_SCAN1;
			end
			cpit_pkg::ST_SCAN1: begin
				cmd.scan_en = 1'b1;
				cmd.scan_first = (scan_q == '0);
				raddr1 = AW'(scan_q + 1'b1);
				if (scan_end) st_d = cpit_pkg::ST_SCAN2;
			end
			cpit_pkg::ST_SCAN2: begin
				cmd.scan_en = 1'b1;
				cmd.scan_first = (scan_q == '0);
				cmd.scan_neg = 1'b1;
				raddr2 = AW'(scan_q + 1'b1);
				if (scan_end) st_d = cpit_pkg::ST_FETCH0;
			end
			cpit_pkg::ST_FETCH0: begin
				raddr1 = best1_q;
				raddr2 = best2_q;
				st_d = cpit_pkg::ST_FETCH1;
			end
			cpit_pkg::ST_FETCH1: begin
				cmd.ld_cur = 1'b1;
				raddr1 = pptr_q;
				raddr2 = qptr_q;
				st_d = cpit_pkg::ST_FETCH2;
			end
			cpit_pkg::ST_FETCH2: begin
				cmd.ld_nxt_p = 1'b1;
				cmd.ld_nxt_q = 1'b1;
				st_d = cpit_pkg::ST_PAIR1;
			end
			cpit_pkg::ST_PAIR1: begin
				if (!have_prev_q) begin
					cmd.store_first = 1'b1;
					st_d = (done_i || done_j) ? cpit_pkg::ST_ADV : cpit_pkg::ST_ANG1;
				end else begin
					cmd.mul1 = 1'b1;
					st_d = cpit_pkg::ST_PAIR2;
				end
			end
			cpit_pkg::ST_PAIR2: begin
				cmd.mul2 = 1'b1;
				st_d = cpit_pkg::ST_PAIR3;
			end
			cpit_pkg::ST_PAIR3: begin
				cmd.pair_upd = 1'b1;
				st_d = (done_i || done_j) ? cpit_pkg::ST_ADV : cpit_pkg::ST_ANG1;
			end
			cpit_pkg::ST_ANG1: begin
				cmd.op = cpit_pkg::OP_ANG;
				cmd.mul1 = 1'b1;
				st_d = cpit_pkg::ST_ANG2;
			end
			cpit_pkg::ST_ANG2: begin
				cmd.op = cpit_pkg::OP_ANG;
				cmd.mul2 = 1'b1;
				st_d = cpit_pkg::ST_ANG3;
			end
			cpit_pkg::ST_ANG3: begin
				cmd.op = cpit_pkg::OP_ANG;
				st_d = cpit_pkg::ST_ADV;
			end
			cpit_pkg::ST_ADV: begin
				cmd.store_prev = 1'b1;
				cmd.shift_p = advp_q;
				cmd.shift_q = advq_q;
				raddr1 = pptr_q;
				raddr2 = qptr_q;
				st_d = cpit_pkg::ST_ADVW;
			end
			cpit_pkg::ST_ADVW: begin
				cmd.ld_nxt_p = advp_q;
				cmd.ld_nxt_q = advq_q;
				st_d = (done_i && done_j) ? cpit_pkg::ST_CLOSE1 : cpit_pkg::ST_PAIR1;
			end
			cpit_pkg::ST_CLOSE1: begin
				cmd.op = cpit_pkg::OP_CLOSE;
				cmd.mul1 = 1'b1;
				st_d = cpit_pkg::ST_CLOSE2;
			end
			cpit_pkg::ST_CLOSE2: begin
				cmd.op = cpit_pkg::OP_CLOSE;
				cmd.mul2 = 1'b1;
				st_d = cpit_pkg::ST_CLOSE3;
			end
			cpit_pkg::ST_CLOSE3: begin
				cmd.op = cpit_pkg::OP_CLOSE;
				cmd.pair_upd = 1'b1;
				st_d = cpit_pkg::ST_OUT;
			end
			cpit_pkg::ST_OUT: begin
				if (out_load) st_d = cpit_pkg::ST_LOAD;
			end
			default: st_d = cpit_pkg::ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n1_q <= '0;
			n2_q <= '0;
			ovf_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (out_load) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
			case (st_q)
				cpit_pkg::ST_LOAD: begin
					if (s_acc) begin
						if (s_sel) begin
							if (n2_q < CAP) n2_q <= n2_q + 1'b1;
							else ovf_q <= 1'b1;
						end else begin
							if (n1_q < CAP) n1_q <= n1_q + 1'b1;
							else ovf_q <= 1'b1;
						end
					end
				end
				cpit_pkg::ST_FETCH2: begin
					i_q <= '0;
					j_q <= '0;
				end
				cpit_pkg::ST_ADV: begin
					if (advp_q) i_q <= i_q + 1'b1;
					if (advq_q) j_q <= j_q + 1'b1;
				end
				cpit_pkg::ST_OUT: begin
					if (out_load) begin
						n1_q <= '0;
						n2_q <= '0;
						ovf_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// walk registers, no reset needed
	always_ff @(posedge clk) begin
		case (st_q)
			cpit_pkg::ST_START: begin
				scan_q <= '0;
				empty_q <= (n1_q == '0 || n2_q == '0);
			end
			cpit_pkg::ST_SCAN1: begin
				if (scan_q == '0 || sts.better) best1_q <= scan_q[AW-1:0];
				scan_q <= scan_end ? '0 : scan_q + 1'b1;
			end
			cpit_pkg::ST_SCAN2: begin
				if (scan_q == '0 || sts.better) best2_q <= scan_q[AW-1:0];
				scan_q <= scan_q + 1'b1;
			end
			cpit_pkg::ST_FETCH0: begin
				pptr_q <= dec_wrap(best1_q, n1_q);
				qptr_q <= dec_wrap(best2_q, n2_q);
			end
			cpit_pkg::ST_FETCH1: begin
				pptr_q <= dec_wrap(pptr_q, n1_q);
				qptr_q <= dec_wrap(qptr_q, n2_q);
			end
			cpit_pkg::ST_FETCH2: begin
				have_prev_q <= 1'b0;
			end
			cpit_pkg::ST_PAIR1, cpit_pkg::ST_PAIR3: begin
				if (st_q == cpit_pkg::ST_PAIR1) have_prev_q <= 1'b1;
				if ((st_q == cpit_pkg::ST_PAIR3) || !have_prev_q) begin
					// one walk already done: only the other side moves
					advp_q <= !done_i;
					advq_q <= done_i;
				end
			end
			cpit_pkg::ST_ANG3: begin
				advp_q <= sts.a_first || !sts.b_first;
				advq_q <= sts.b_first || !sts.a_first;
			end
			cpit_pkg::ST_ADV: begin
				if (advp_q) pptr_q <= dec_wrap(pptr_q, n1_q);
				if (advq_q) qptr_q <= dec_wrap(qptr_q, n2_q);
			end
			cpit_pkg::ST_OUT: begin
				if (out_load) begin
					res_q <= !empty_q && sts.hit;
					res_ovf_q <= ovf_q;
				end
			end
			default: ;
		endcase
	end

	`CPIT_ASSERT(a_cap, (n1_q <= CAP) && (n2_q <= CAP), "vertex count beyond capacity")
	`CPIT_ASSERT(a_walk, (st_q == cpit_pkg::ST_ANG1) |-> (!done_i && !done_j), "angle at walk end")
	`CPIT_ASSERT(a_step, (st_q == cpit_pkg::ST_ADVW) |-> (advp_q || advq_q), "merge step without progress")
	`CPIT_ASSERT_NEXT(a_clear, out_load, (n1_q == '0) && (n2_q == '0) && !ovf_q, "counts kept after result")

endmodule

### hdl/convex_polygon_intersection_test.sv
// top level: convex polygon intersection test by minkowski difference
// load: one vertex beat per cycle, no result for a vertex beat
// compute, after the second polygon's last beat: setup and start search over both polygons,
// then at most n1 + n2 merge steps on the shared multiplier,
// then the closing edge and the result; inputs are held off meanwhile
// reset clears counts, overflow flag and output valid; vertex stores need no clearing pass
module convex_polygon_intersection_test #(
	parameter int MAX_VERTICES = cpit_pkg::MAX_VERTICES_DEF,
	parameter int COORD_BITS   = cpit_pkg::COORD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // x_coord, y_coord
	input  logic [0:0]  s_tuser,  // polygon_select
	input  logic        s_tlast,  // last_vertex
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata   // intersects, overflow, zero fill
);

	localparam int AW = $clog2(MAX_VERTICES);

	logic we1, we2, intersects, overflow;
	logic [AW-1:0] waddr, raddr1, raddr2;
	logic [63:0] wdata, rdata1, rdata2;
	cpit_pkg::dp_cmd_t cmd;
	cpit_pkg::dp_sts_t sts;

	cpit_ram #(.W(64), .D(MAX_VERTICES)) u_ram1 (
		.clk(clk), .we(we1), .waddr(waddr), .wdata(wdata), .raddr(raddr1), .rdata(rdata1)
	);

	cpit_ram #(.W(64), .D(MAX_VERTICES)) u_ram2 (
		.clk(clk), .we(we2), .waddr(waddr), .wdata(wdata), .raddr(raddr2), .rdata(rdata2)
	);

	cpit_dp #(.COORD_BITS(COORD_BITS)) u_dp (
		.clk(clk),
		.x_coord(s_tdata[31:0]),
		.y_coord(s_tdata[63:32]),
		.wdata(wdata),
		.rdata1(rdata1),
		.rdata2(rdata2),
		.cmd(cmd),
		.sts(sts)
	);

	cpit_ctrl #(.MAX_VERTICES(MAX_VERTICES)) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_sel(s_tuser[0]),
		.s_last(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_intersects(intersects),
		.m_overflow(overflow),
		.we1(we1),
		.we2(we2),
		.waddr(waddr),
		.raddr1(raddr1),
		.raddr2(raddr2),
		.cmd(cmd),
		.sts(sts)
	);

	assign m_tdata = {6'b0, overflow, intersects};

endmodule

### sim/tb_convex_polygon_intersection_test.sv
// testbench for the convex polygon intersection test: vertex streams in, verdict beats checked
module tb_convex_polygon_intersection_test;

	localparam int CAP = cpit_pkg::MAX_VERTICES_DEF;
	localparam real PI = 3.14159265358979;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic [0:0]  s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;

	int src_idle_pct;
	int sink_stall_pct;
	int err_cnt;
	int vertex_cnt;
	int verdict_cnt;
	int hit_cnt;

	// predictor state: raw stored vertices per polygon, counts and drop flag
	logic [31:0] vtx_x [2][CAP];
	logic [31:0] vtx_y [2][CAP];
	int          vtx_cnt [2];
	bit          drop_seen;
	longint      dif_x [2*CAP];
	longint      dif_y [2*CAP];
	logic [1:0]  verdict_q [$];   // bit 0 intersects, bit 1 overflow

	convex_polygon_intersection_test DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		clk = 1'b1; #6;
		clk = 1'b0; #6;
	end

	function automatic void vertex_at(int p, int n, int start, int k, output longint x,
			output longint y);
		int idx;
		idx = (start + n - (k % n)) % n;
		x = longint'($signed(vtx_x[p][idx]));
		y = longint'($signed(vtx_y[p][idx]));
		if (p == 1) begin
			x = -x;
			y = -y;
		end
	endfunction

	// sign of a*b - c*d, exact
	function automatic int cross_sign(longint a, longint b, longint c, longint d);
		logic signed [127:0] r;
		r = 128'(signed'(a)) * 128'(signed'(b)) - 128'(signed'(c)) * 128'(signed'(d));
		if (r < 0) return -1;
		return (r != 0) ? 1 : 0;
	endfunction

	function automatic int dir_class(longint x, longint y);
		if (x > 0) return 0;
		if (x == 0 && y > 0) return 1;
		if (x < 0) return 2;
		return 3;
	endfunction

	function automatic int angle_order(longint ax, longint ay, longint bx, longint by);
		int ga, gb, c;
		ga = dir_class(ax, ay);
		gb = dir_class(bx, by);
		if (ga != gb) return (ga < gb) ? -1 : 1;
		if (ga == 1 || ga == 3) return 0;
		c = cross_sign(ax, by, ay, bx);
		return (c > 0) ? -1 : ((c < 0) ? 1 : 0);
	endfunction

	function automatic int lowest_vertex(int p, int n);
		int best;
		longint bx, by, x, y;
		best = 0;
		vertex_at(p, n, 0, 0, bx, by);
		for (int i = 1; i < n; i++) begin
			vertex_at(p, n, i, 0, x, y);
			if (x < bx || (x == bx && y < by)) begin
				best = i; bx = x; by = y;
			end
		end
		return best;
	endfunction

	function automatic bit origin_in_difference();
		int n1, n2, s1, s2, i, j, m, c, s, nx;
		longint px, py, qx, qy, px1, py1, qx1, qy1, ax, ay, bx, by;
		bit le, ge;
		n1 = vtx_cnt[0]; n2 = vtx_cnt[1];
		i = 0; j = 0; m = 0; le = 0; ge = 0;
		if (n1 == 0 || n2 == 0) return 0;
		s1 = lowest_vertex(0, n1);
		s2 = lowest_vertex(1, n2);
		while ((i < n1 || j < n2) && m < 2*CAP) begin
			vertex_at(0, n1, s1, i, px, py);
			vertex_at(1, n2, s2, j, qx, qy);
			dif_x[m] = px + qx;
			dif_y[m] = py + qy;
			m++;
			if (i >= n1) j++;
			else if (j >= n2) i++;
			else begin
				vertex_at(0, n1, s1, i + 1, px1, py1);
				vertex_at(1, n2, s2, j + 1, qx1, qy1);
				c = angle_order(px1 - px, py1 - py, qx1 - qx, qy1 - qy);
				if (c < 0) i++;
				else if (c > 0) j++;
				else begin i++; j++; end
			end
		end
		for (int k = 0; k < m; k++) begin
			nx = (k + 1) % m;
			ax = dif_x[k]; ay = dif_y[k]; bx = dif_x[nx]; by = dif_y[nx];
			if (ay == 0) begin
				if (ax <= 0) le = 1;
				if (ax >= 0) ge = 1;
			end
			if ((ay < 0 && by > 0) || (ay > 0 && by < 0)) begin
				s = cross_sign(ax, by, bx, ay);
				if (by < ay) s = -s;
				if (s <= 0) le = 1;
				if (s >= 0) ge = 1;
			end
		end
		return le && ge;
	endfunction

	function automatic void take_vertex(bit sel, logic [31:0] x, logic [31:0] y, bit last);
		bit hit;
		if (vtx_cnt[sel] < CAP) begin
			vtx_x[sel][vtx_cnt[sel]] = x;
			vtx_y[sel][vtx_cnt[sel]] = y;
			vtx_cnt[sel]++;
		end else
			drop_seen = 1;
		if (sel && last) begin
			hit = origin_in_difference();
			verdict_q.insert(verdict_q.size(), {drop_seen, hit});
			vtx_cnt[0] = 0;
			vtx_cnt[1] = 0;
			drop_seen = 0;
		end
	endfunction

	task automatic send_vertex(bit sel, logic [31:0] x, logic [31:0] y, bit last);
		@(negedge clk);
		if ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {y, x};
		s_tuser  <= sel;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		take_vertex(sel, x, y, last);
		vertex_cnt++;
	endtask

	task automatic wait_verdicts();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [31:0] clamp32(real v);
		if (v > 2147483647.0) return 32'h7fffffff;
		if (v < -2147483648.0) return 32'h80000000;
		return 32'(longint'(v));
	endfunction

	// regular-ish polygon with jittered angles, clockwise unless reversed
	task automatic send_ring(bit sel, int n, real cx, real cy, real r, bit reversed);
		real a0, a;
		a0 = $urandom_range(0, 6283) / 1000.0;
		for (int i = 0; i < n; i++) begin
			a = a0 + (reversed ? 1.0 : -1.0) * 2.0 * PI * (i + $urandom_range(0, 40) / 100.0) / n;
			send_vertex(sel, clamp32(cx + r * $cos(a)), clamp32(cy + r * $sin(a)), i == n - 1);
		end
	endtask

	task automatic send_square(bit sel, int x0, int y0, int x1, int y1);
		send_vertex(sel, x0, y0, 0);
		send_vertex(sel, x0, y1, 0);
		send_vertex(sel, x1, y1, 0);
		send_vertex(sel, x1, y0, 1);
	endtask

	task automatic test_directed();
		src_idle_pct = 0; sink_stall_pct = 0;
		send_square(0, 0, 0, 10, 10);  send_square(1, 5, 5, 15, 15);    // overlap
		send_square(0, 0, 0, 10, 10);  send_square(1, 20, 20, 30, 30);  // apart
		send_square(0, 0, 0, 10, 10);  send_square(1, 10, 0, 20, 10);   // shared edge
		send_square(0, 0, 0, 10, 10);  send_square(1, 10, 10, 20, 20);  // corner touch
		send_vertex(0, 3, 4, 1);       send_vertex(1, 3, 4, 1);         // equal points
		send_vertex(1, 1, 1, 1);                                        // empty first polygon
		// first polygon resumed after its last beat, segment against point
		send_vertex(0, 0, 0, 1);
		send_vertex(0, 8, 8, 0);
		send_vertex(1, 4, 4, 1);
		send_square(0, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
		send_square(1, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
		// counterclockwise input
		send_vertex(0, 0, 0, 0); send_vertex(0, 10, 0, 0); send_vertex(0, 5, 9, 1);
		send_vertex(1, 5, 3, 0); send_vertex(1, 6, 3, 0); send_vertex(1, 5, 4, 1);
		wait_verdicts();
	endtask

	task automatic test_random_pairs();
		int idle_set [4][2] = '{'{0, 0}, '{61, 0}, '{0, 61}, '{17, 17}};
		real spread;
		for (int ph = 0; ph < 4; ph++) begin
			src_idle_pct = idle_set[ph][0];
			sink_stall_pct = idle_set[ph][1];
			for (int k = 0; k < 12; k++) begin
				if ($urandom_range(9) == 0) begin
					// unordered junk, full-range coordinates
					repeat ($urandom_range(1, 5)) send_vertex(0, $urandom, $urandom, 0);
					send_vertex(0, $urandom, $urandom, 1);
					repeat ($urandom_range(0, 5)) send_vertex(1, $urandom, $urandom, 0);
					send_vertex(1, $urandom, $urandom, 1);
				end else begin
					spread = ($urandom_range(3) == 0) ? 1.5e9 : 2000.0;
					send_ring(0, $urandom_range(1, 8), 0.0, 0.0, spread * $urandom_range(1, 100) / 100.0,
						$urandom_range(15) == 0);
					send_ring(1, $urandom_range(1, 8),
						spread * ($urandom_range(0, 200) - 100.0) / 100.0,
						spread * ($urandom_range(0, 200) - 100.0) / 100.0,
						spread * $urandom_range(1, 100) / 100.0, 0);
				end
			end
			// hold off the sender until every verdict of this phase is in
			wait_verdicts();
		end
	endtask

	always @(negedge clk) m_tready <= ($urandom_range(99) >= sink_stall_pct);

	always @(posedge clk) begin
		logic [1:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (verdict_q.size() == 0) begin
				$error("verdict beat with nothing expected: %h", m_tdata);
				err_cnt++;
			end else begin
				want = verdict_q.pop_front();
				verdict_cnt++;
				if (want[0]) hit_cnt++;
				if (m_tdata[0] !== want[0]) begin
					$error("intersects: expected %0d, got %0d", want[0], m_tdata[0]);
					err_cnt++;
				end
				if (m_tdata[1] !== want[1]) begin
					$error("overflow: expected %0d, got %0d", want[1], m_tdata[1]);
					err_cnt++;
				end
				if (m_tdata[7:2] !== 6'd0) begin
					$error("fill: expected 0, got %h", m_tdata[7:2]);
					err_cnt++;
				end
			end
		end
	end

	initial begin
		#12000000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0; s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0; s_tlast = 1'b0;
		m_tready = 1'b0;
		src_idle_pct = 0; sink_stall_pct = 0;
		err_cnt = 0; vertex_cnt = 0; verdict_cnt = 0; hit_cnt = 0;
		vtx_cnt[0] = 0; vtx_cnt[1] = 0; drop_seen = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random_pairs();
		if (verdict_q.size() != 0) begin
			$error("%0d verdicts never arrived", verdict_q.size());
			err_cnt++;
		end
		$display("%0d vertex beats, %0d verdicts checked (%0d intersecting), %0d mismatches",
			vertex_cnt, verdict_cnt, hit_cnt, err_cnt);
		$display("covered touching, degenerate, extreme and unordered polygons under stalls");
		if (err_cnt == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

### convex_polygon_intersection_test.f
+incdir+hdl
hdl/cpit_pkg.sv
hdl/cpit_ram.sv
hdl/cpit_dp.sv
hdl/cpit_ctrl.sv
hdl/convex_polygon_intersection_test.sv
sim/tb_convex_polygon_intersection_test.sv
